[rtl/lvn_pkg.sv]
package lvn_pkg;

	localparam int NODE_DEPTH_DEF   = 128;
	localparam int SYMBOL_COUNT_DEF = 256;

	localparam int SYM_IN_W   = 8;
	localparam int SYM_IN_NUM = 1 << SYM_IN_W;
	localparam int OP_W       = 4;
	localparam int RES_NODE_W = 7;

	localparam logic [OP_W-1:0] OP_COPY = 4'd0;

	typedef struct packed {
		logic [SYM_IN_W-1:0] result_symbol;
		logic [OP_W-1:0]     op_code;
		logic [SYM_IN_W-1:0] first_symbol;
		logic [SYM_IN_W-1:0] second_symbol;
	} cmd_beat_t;

	typedef struct packed {
		logic [RES_NODE_W-1:0] result_node;
		logic                  reused;
		logic                  table_full;
	} rsp_beat_t;

endpackage

[rtl/local_value_numbering.sv]
// A command reads its operand map entries, may scan the stored nodes one entry a cycle until a
// match, then writes any new leaf and node entries and maps the result before the response beat.
// One command at a time: the next is taken once the response is registered.
// Reset: asynchronous, clears control state, then a clearing pass over all SYMBOL_COUNT entries
// marks every symbol map entry invalid while cmd_stall stays high.
module local_value_numbering #(
	parameter int NODE_DEPTH   = lvn_pkg::NODE_DEPTH_DEF,
	parameter int SYMBOL_COUNT = lvn_pkg::SYMBOL_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  lvn_pkg::cmd_beat_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output lvn_pkg::rsp_beat_t rsp
);

	localparam int NODE_W = $clog2(NODE_DEPTH);
	localparam int CNT_W  = $clog2(NODE_DEPTH + 1);
	localparam int SYM_W  = $clog2(SYMBOL_COUNT);

	typedef struct packed {
		logic                     leaf;
		logic [lvn_pkg::OP_W-1:0] op;
		logic [NODE_W-1:0]        left;
		logic [NODE_W-1:0]        right;
	} node_t;

	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] node;
	} map_t;

	typedef enum logic [11:0] {
		S_CLEAR   = 12'b0000_0000_0001,
		S_IDLE    = 12'b0000_0000_0010,
		S_RD_A    = 12'b0000_0000_0100,
		S_RD_B    = 12'b0000_0000_1000,
		S_LOOKUP  = 12'b0000_0001_0000,
		S_SCAN    = 12'b0000_0010_0000,
		S_DECIDE  = 12'b0000_0100_0000,
		S_LEAF_A  = 12'b0000_1000_0000,
		S_LEAF_B  = 12'b0001_0000_0000,
		S_NODE    = 12'b0010_0000_0000,
		S_MAP_RES = 12'b0100_0000_0000,
		S_DONE    = 12'b1000_0000_0000
	} state_t;

	state_t state_q;

	map_t  map_mem [SYMBOL_COUNT];
	node_t node_mem [NODE_DEPTH];
	map_t  map_rd_q;
	node_t node_rd_q;

	logic [SYM_W-1:0] sym_tbl [lvn_pkg::SYM_IN_NUM];

	logic [SYM_W-1:0]         clr_q;
	logic [SYM_W-1:0]         res_q;
	logic [SYM_W-1:0]         a_q;
	logic [SYM_W-1:0]         b_q;
	logic [lvn_pkg::OP_W-1:0] op_q;
	logic                     a_v_q;
	logic                     b_v_q;
	logic [NODE_W-1:0]        a_node_q;
	logic [NODE_W-1:0]        b_node_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [CNT_W-1:0]         scan_q;
	logic                     cmp_v_q;
	logic [NODE_W-1:0]        cmp_idx_q;
	logic                     match_q;
	logic [NODE_W-1:0]        res_node_q;
	logic                     reused_q;
	logic                     full_q;
	logic                     rsp_valid_q;
	lvn_pkg::rsp_beat_t       rsp_q;

	logic              is_copy;
	logic              scan_issue;
	logic              scan_hit;
	logic [1:0]        need;
	logic [CNT_W:0]    need_sum;
	logic              no_room;
	logic              b_is_a;
	logic [SYM_W-1:0]  map_raddr;
	logic              map_we;
	logic [SYM_W-1:0]  map_waddr;
	map_t              map_wdata;
	logic              node_we;
	node_t             node_wdata;
	logic [NODE_W+lvn_pkg::RES_NODE_W-1:0] res_ext;

	for (genvar g = 0; g < lvn_pkg::SYM_IN_NUM; g++) begin : g_sym
		assign sym_tbl[g] = SYM_W'(g % SYMBOL_COUNT);
	end

	assign is_copy    = (op_q == lvn_pkg::OP_COPY);
	assign b_is_a     = (b_q == a_q);
	assign scan_issue = (scan_q < cnt_q);
	assign scan_hit   = cmp_v_q && !node_rd_q.leaf && (node_rd_q.op == op_q) &&
	                    (node_rd_q.left == a_node_q) && (node_rd_q.right == b_node_q);

	assign need = 2'(!a_v_q) + 2'(!is_copy && !b_v_q && !b_is_a) + 2'(!is_copy && !match_q);
	assign need_sum = {1'b0, cnt_q} + (CNT_W+1)'(need);
	assign no_room  = need_sum > (CNT_W+1)'(NODE_DEPTH);

	assign map_raddr = (state_q == S_RD_B) ? b_q : a_q;

	always_comb begin
		map_we     = 1'b0;
		map_waddr  = clr_q;
		map_wdata  = '0;
		node_we    = 1'b0;
		node_wdata = '{leaf: 1'b1, op: '0, left: '0, right: '0};
		case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
			end
			S_LEAF_A: begin
				map_we    = 1'b1;
				map_waddr = a_q;
				map_wdata = '{valid: 1'b1, node: cnt_q[NODE_W-1:0]};
				node_we   = 1'b1;
			end
			S_LEAF_B: begin
				map_we    = 1'b1;
				map_waddr = b_q;
				map_wdata = '{valid: 1'b1, node: cnt_q[NODE_W-1:0]};
				node_we   = 1'b1;
			end
			S_NODE: begin
				node_we    = 1'b1;
				node_wdata = '{leaf: 1'b0, op: op_q, left: a_node_q, right: b_node_q};
			end
			S_MAP_RES: begin
				map_we    = 1'b1;
				map_waddr = res_q;
				map_wdata = '{valid: 1'b1, node: is_copy ? a_node_q : res_node_q};
			end
			default: begin
				map_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem[map_waddr] <= map_wdata;
		end
		map_rd_q <= map_mem[map_raddr];
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[cnt_q[NODE_W-1:0]] <= node_wdata;
		end
		node_rd_q <= node_mem[scan_q[NODE_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			res_q       <= '0;
			a_q         <= '0;
			b_q         <= '0;
			op_q        <= '0;
			a_v_q       <= 1'b0;
			b_v_q       <= 1'b0;
			a_node_q    <= '0;
			b_node_q    <= '0;
			cnt_q       <= '0;
			scan_q      <= '0;
			cmp_v_q     <= 1'b0;
			cmp_idx_q   <= '0;
			match_q     <= 1'b0;
			res_node_q  <= '0;
			reused_q    <= 1'b0;
			full_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SYM_W'(SYMBOL_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						res_q   <= sym_tbl[cmd.result_symbol];
						op_q    <= cmd.op_code;
						a_q     <= sym_tbl[cmd.first_symbol];
						b_q     <= sym_tbl[cmd.second_symbol];
						state_q <= S_RD_A;
					end
				end
				S_RD_A: begin
					state_q <= S_RD_B;
				end
				S_RD_B: begin
					a_v_q    <= map_rd_q.valid;
					a_node_q <= map_rd_q.node;
					state_q  <= S_LOOKUP;
				end
				S_LOOKUP: begin
					b_v_q    <= map_rd_q.valid;
					b_node_q <= map_rd_q.node;
					match_q  <= 1'b0;
					scan_q   <= '0;
					cmp_v_q  <= 1'b0;
					if (!is_copy && a_v_q && map_rd_q.valid) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_SCAN: begin
					cmp_v_q   <= scan_issue;
					cmp_idx_q <= scan_q[NODE_W-1:0];
					if (scan_issue) begin
						scan_q <= scan_q + 1'b1;
					end
					if (scan_hit) begin
						match_q    <= 1'b1;
						res_node_q <= cmp_idx_q;
						state_q    <= S_DECIDE;
					end else if (!scan_issue && !cmp_v_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (no_room) begin
						full_q     <= 1'b1;
						reused_q   <= 1'b0;
						res_node_q <= '0;
						state_q    <= S_DONE;
					end else begin
						full_q   <= 1'b0;
						reused_q <= match_q;
						if (!a_v_q) begin
							state_q <= S_LEAF_A;
						end else if (!is_copy && !b_v_q) begin
							state_q <= S_LEAF_B;
						end else if (!is_copy && !match_q) begin
							state_q <= S_NODE;
						end else begin
							state_q <= S_MAP_RES;
						end
					end
				end
				S_LEAF_A: begin
					a_v_q    <= 1'b1;
					a_node_q <= cnt_q[NODE_W-1:0];
					cnt_q    <= cnt_q + 1'b1;
					if (b_is_a) begin
						b_v_q    <= 1'b1;
						b_node_q <= cnt_q[NODE_W-1:0];
					end
					if (!is_copy && !b_v_q && !b_is_a) begin
						state_q <= S_LEAF_B;
					end else if (!is_copy && !match_q) begin
						state_q <= S_NODE;
					end else begin
						state_q <= S_MAP_RES;
					end
				end
				S_LEAF_B: begin
					b_v_q    <= 1'b1;
					b_node_q <= cnt_q[NODE_W-1:0];
					cnt_q    <= cnt_q + 1'b1;
					state_q  <= S_NODE;
				end
				S_NODE: begin
					res_node_q <= cnt_q[NODE_W-1:0];
					cnt_q      <= cnt_q + 1'b1;
					state_q    <= S_MAP_RES;
				end
				S_MAP_RES: begin
					res_node_q <= map_wdata.node;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.result_node <= res_ext[lvn_pkg::RES_NODE_W-1:0];
						rsp_q.reused      <= reused_q;
						rsp_q.table_full  <= full_q;
						rsp_valid_q       <= 1'b1;
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_ext   = (NODE_W+lvn_pkg::RES_NODE_W)'(res_node_q);
	assign cmd_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(NODE_DEPTH))
		else $error("node count beyond depth");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + 1'b1))
		else $error("node count moved by more than one");

	a_full_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.table_full |-> (rsp.result_node == '0) && !rsp.reused)
		else $error("full response carries a node");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> (state_q == S_RD_A))
		else $error("accepted beat did not start a lookup");

	a_full_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DECIDE) && no_room |=> (cnt_q == $past(cnt_q)) && (state_q == S_DONE))
		else $error("full table changed state");

endmodule

[sim/tb_top.sv]
module tb_top;

	localparam int ITEM_TOTAL   = 1050;
	localparam int HOLD_MAX     = 13;
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 1_200_000;

	logic               clk;
	logic               arst_n;
	logic               cmd_valid = 1'b0;
	logic               cmd_stall;
	lvn_pkg::cmd_beat_t cmd = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	lvn_pkg::rsp_beat_t rsp;

	lvn_pkg::cmd_beat_t instr_q[$];
	lvn_pkg::rsp_beat_t node_result_q[$];
	int                 beats_sent = 0;
	int                 mismatches = 0;

	bit                       sym_bound [lvn_pkg::SYMBOL_COUNT_DEF];
	int                       sym_node  [lvn_pkg::SYMBOL_COUNT_DEF];
	bit                       node_leaf [lvn_pkg::NODE_DEPTH_DEF];
	logic [lvn_pkg::OP_W-1:0] node_op   [lvn_pkg::NODE_DEPTH_DEF];
	int                       node_left [lvn_pkg::NODE_DEPTH_DEF];
	int                       node_right[lvn_pkg::NODE_DEPTH_DEF];
	int                       nodes_used = 0;

	int cmd_gap = 0;
	bit cmd_burst = 1'b0;
	int rsp_hold = 0;
	bit rsp_burst = 1'b0;

	local_value_numbering dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic int add_leaf(int s);
		int idx;
		idx = nodes_used;
		node_leaf[idx]  = 1'b1;
		node_op[idx]    = lvn_pkg::OP_COPY;
		node_left[idx]  = 0;
		node_right[idx] = 0;
		nodes_used++;
		sym_bound[s] = 1'b1;
		sym_node[s]  = idx;
		return idx;
	endfunction

	function automatic lvn_pkg::rsp_beat_t number_value(lvn_pkg::cmd_beat_t c);
		lvn_pkg::rsp_beat_t r;
		int        dst;
		int        a;
		int        b;
		int        need;
		int        n;
		int        n1;
		int        n2;
		bit        hit;
		r    = '0;
		need = 0;
		n    = 0;
		hit  = 1'b0;
		dst  = int'(c.result_symbol) % lvn_pkg::SYMBOL_COUNT_DEF;
		a    = int'(c.first_symbol) % lvn_pkg::SYMBOL_COUNT_DEF;
		b    = int'(c.second_symbol) % lvn_pkg::SYMBOL_COUNT_DEF;
		if (c.op_code == lvn_pkg::OP_COPY) begin
			if (!sym_bound[a]) need = 1;
			if (nodes_used + need > lvn_pkg::NODE_DEPTH_DEF) begin
				r.table_full = 1'b1;
				return r;
			end
			n = sym_bound[a] ? sym_node[a] : add_leaf(a);
			sym_bound[dst] = 1'b1;
			sym_node[dst]  = n;
			r.result_node  = n[lvn_pkg::RES_NODE_W-1:0];
			return r;
		end
		if (!sym_bound[a]) need++;
		if (!sym_bound[b] && b != a) need++;
		if (sym_bound[a] && sym_bound[b]) begin
			for (int i = 0; i < nodes_used; i++) begin
				if (!hit && !node_leaf[i] && node_op[i] == c.op_code &&
						node_left[i] == sym_node[a] && node_right[i] == sym_node[b]) begin
					hit = 1'b1;
					n   = i;
				end
			end
		end
		if (!hit) need++;
		if (nodes_used + need > lvn_pkg::NODE_DEPTH_DEF) begin
			r.table_full = 1'b1;
			return r;
		end
		n1 = sym_bound[a] ? sym_node[a] : add_leaf(a);
		n2 = sym_bound[b] ? sym_node[b] : add_leaf(b);
		if (!hit) begin
			n             = nodes_used;
			node_leaf[n]  = 1'b0;
			node_op[n]    = c.op_code;
			node_left[n]  = n1;
			node_right[n] = n2;
			nodes_used++;
		end
		sym_bound[dst] = 1'b1;
		sym_node[dst]  = n;
		r.result_node  = n[lvn_pkg::RES_NODE_W-1:0];
		r.reused       = hit;
		return r;
	endfunction

	task automatic push_instr(int dst, int op, int a, int b);
		lvn_pkg::cmd_beat_t c;
		c.result_symbol = dst[lvn_pkg::SYM_IN_W-1:0];
		c.op_code       = op[lvn_pkg::OP_W-1:0];
		c.first_symbol  = a[lvn_pkg::SYM_IN_W-1:0];
		c.second_symbol = b[lvn_pkg::SYM_IN_W-1:0];
		instr_q.push_back(c);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_valid && !cmd_stall) begin
				node_result_q.push_back(number_value(cmd));
				beats_sent++;
			end
			if (!(cmd_valid && cmd_stall)) begin
				if (cmd_gap > 0) begin
					cmd_gap   <= cmd_gap - 1;
					cmd_valid <= 1'b0;
				end else if (instr_q.size() > 0) begin
					cmd       <= instr_q.pop_front();
					cmd_valid <= 1'b1;
					if ($urandom_range(0, 39) == 0) cmd_burst <= !cmd_burst;
					cmd_gap <= cmd_burst ? 0 : $urandom_range(0, HOLD_MAX);
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		lvn_pkg::rsp_beat_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (node_result_q.size() == 0) begin
					report_mismatch("beat with nothing pending, result_node",
						rsp.result_node, 0);
				end else begin
					want = node_result_q.pop_front();
					if (rsp.result_node !== want.result_node)
						report_mismatch("result_node", rsp.result_node, want.result_node);
					if (rsp.reused !== want.reused)
						report_mismatch("reused", rsp.reused, want.reused);
					if (rsp.table_full !== want.table_full)
						report_mismatch("table_full", rsp.table_full, want.table_full);
				end
				if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
				rsp_hold = rsp_burst ? 0 : $urandom_range(0, HOLD_MAX);
			end else if (rsp_hold > 0 && (rsp_valid || $urandom_range(0, 1) == 1)) begin
				rsp_hold--;
			end
			rsp_stall <= (rsp_hold > 0);
		end
	end

	initial begin
		lvn_pkg::cmd_beat_t recent_q[$];
		lvn_pkg::cmd_beat_t c;
		int        kind;
		int        pool;
		int        op_top;
		int        s;
		arst_n = 1'b0;

		push_instr(255, lvn_pkg::OP_COPY, 0, 255);
		push_instr(1, 1, 2, 2);
		push_instr(3, 1, 2, 2);
		push_instr(0, 15, 255, 0);
		push_instr(4, 15, 255, 0);
		push_instr(5, lvn_pkg::OP_COPY, 1, 170);
		push_instr(6, 2, 5, 1);
		push_instr(7, 2, 3, 1);
		push_instr(8, lvn_pkg::OP_COPY, 9, 10);
		push_instr(2, 3, 2, 8);
		push_instr(11, 3, 9, 8);
		for (int op = 4; op <= 14; op++) begin
			push_instr(16 + op, op, 30 + op, op);
		end
		push_instr(254, 14, 44, 14);
		push_instr(253, lvn_pkg::OP_COPY, 254, 0);

		for (int i = instr_q.size(); i < ITEM_TOTAL; i++) begin
			pool   = (i < 400) ? 31 : 255;
			op_top = (i < 400) ? 3 : 15;
			kind   = $urandom_range(0, 99);
			s      = $urandom_range(0, pool);
			if (kind < 35) begin
				c.result_symbol = s[lvn_pkg::SYM_IN_W-1:0];
				c.op_code       = lvn_pkg::OP_W'($urandom_range(1, op_top));
				c.first_symbol  = lvn_pkg::SYM_IN_W'($urandom_range(0, pool));
				c.second_symbol = lvn_pkg::SYM_IN_W'($urandom_range(0, pool));
				recent_q.push_back(c);
			end else if (kind < 60 && recent_q.size() > 0) begin
				c = recent_q[$urandom_range(0, recent_q.size() - 1)];
				c.result_symbol = s[lvn_pkg::SYM_IN_W-1:0];
			end else if (kind < 75) begin
				c.result_symbol = s[lvn_pkg::SYM_IN_W-1:0];
				c.op_code       = lvn_pkg::OP_COPY;
				c.first_symbol  = lvn_pkg::SYM_IN_W'($urandom_range(0, pool));
				c.second_symbol = lvn_pkg::SYM_IN_W'($urandom);
			end else if (kind < 85) begin
				c.result_symbol = s[lvn_pkg::SYM_IN_W-1:0];
				c.op_code       = lvn_pkg::OP_W'($urandom_range(1, 15));
				c.first_symbol  = lvn_pkg::SYM_IN_W'($urandom_range(0, pool));
				c.second_symbol = c.first_symbol;
				recent_q.push_back(c);
			end else begin
				c = lvn_pkg::cmd_beat_t'($urandom);
			end
			if (recent_q.size() > 16) void'(recent_q.pop_front());
			instr_q.push_back(c);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (beats_sent < ITEM_TOTAL || node_result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && node_result_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#(12 * CYCLE_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
